/* design/lbp_pkg.sv */
package lbp_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ON    = 2'd1,
        ACT_OFF   = 2'd2,
        ACT_FLASH = 2'd3
    } action_t;

    localparam int LEVEL_W = 8;
    localparam int IDX_W   = 4;
    localparam int MASK_W  = 14;
    localparam int CMP_W   = 7;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic CFG_PWM_LEVELS    = 1'b0;
    localparam logic CFG_RAMP_INTERVAL = 1'b1;

    localparam logic [LEVEL_W-1:0] PWM_LEVELS_RST    = 8'd10;
    localparam logic [LEVEL_W-1:0] RAMP_INTERVAL_RST = 8'd20;

endpackage

/* design/led_breathing_pwm_bank_unit.sv */
// Breathing LED bank driven by software PWM.
// Input channel (s_*): one item per tick or command. s_tuser carries the
// action (tick, turn on, turn off, start flash), s_tdata the LED index.
// Output channel (m_*): exactly one result item per input item, carrying the
// lit mask, the flashing mask and whether the addressed LED is flashing.
// The item is accepted, state and result are updated at the same edge, and the
// result is shown from the output register.
// Throughput is one item per cycle; all LEDs update in parallel from small
// compares against the shared PWM and ramp phase counters.
// When the receiver stalls, the result is held in the output register and
// s_tready drops until it is taken; taking it reopens the input in the same
// cycle. Reset clears both phase counters, sets every LED idle, unlit and at
// level zero, loads pwm_levels = 10 and ramp_interval = 20, and empties the
// output. Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must do so only while idle, and the block itself does not enforce this.
module led_breathing_pwm_bank_unit #(
    parameter int LED_COUNT = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [lbp_pkg::LEVEL_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] led_index, [7:4] zero
    input  logic [lbp_pkg::IN_DATA_W-1:0]       s_tdata,
    // [1:0] action
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [13:0] led_on_mask, [27:14] flashing_mask, [28] index_flashing, [31:29] zero
    output logic [lbp_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int LW = lbp_pkg::LEVEL_W;
    localparam int MW = lbp_pkg::MASK_W;

    logic [LW-1:0]       pwm_levels_reg;
    logic [LW-1:0]       ramp_interval_reg;
    logic [LW-1:0]       pwm_phase_reg;
    logic [LW-1:0]       pwm_phase_next;
    logic [LW-1:0]       ramp_phase_reg;
    logic [LW-1:0]       ramp_phase_next;
    lbp_pkg::mode_t      mode_reg  [LED_COUNT];
    lbp_pkg::mode_t      mode_next [LED_COUNT];
    logic [LW-1:0]       level_reg  [LED_COUNT];
    logic [LW-1:0]       level_next [LED_COUNT];
    logic [LED_COUNT-1:0] lit_reg;
    logic [LED_COUNT-1:0] lit_next;
    logic                out_valid_reg;
    logic [lbp_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [lbp_pkg::OUT_DATA_W-1:0] out_data_next;

    logic                    accept;
    lbp_pkg::action_t        action;
    logic [lbp_pkg::IDX_W-1:0] led_index;
    logic [LW:0]             pwm_inc;
    logic [LW:0]             ramp_inc;
    logic [MW-1:0]           on_mask;
    logic [MW-1:0]           fl_mask;
    logic                    index_flashing;

    assign action    = lbp_pkg::action_t'(s_tuser);
    assign led_index = s_tdata[lbp_pkg::IDX_W-1:0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign pwm_inc  = {1'b0, pwm_phase_reg} + {{LW{1'b0}}, 1'b1};
    assign ramp_inc = {1'b0, ramp_phase_reg} + {{LW{1'b0}}, 1'b1};

    always_comb
    begin
        pwm_phase_next  = pwm_phase_reg;
        ramp_phase_next = ramp_phase_reg;
        if (action == lbp_pkg::ACT_TICK)
        begin
            pwm_phase_next  = (pwm_inc >= {1'b0, pwm_levels_reg}) ? '0 : pwm_inc[LW-1:0];
            ramp_phase_next = (ramp_inc > {1'b0, ramp_interval_reg}) ? '0 : ramp_inc[LW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            mode_next[i]  = mode_reg[i];
            level_next[i] = level_reg[i];
            lit_next[i]   = lit_reg[i];
            if (action == lbp_pkg::ACT_TICK)
            begin
                if (mode_reg[i] != lbp_pkg::MODE_IDLE)
                begin
                    if (level_reg[i] == '0)
                        lit_next[i] = 1'b0;
                    else if (level_reg[i] == pwm_levels_reg)
                        lit_next[i] = 1'b1;
                    else if (pwm_phase_next == '0)
                        lit_next[i] = 1'b1;
                    else if (pwm_phase_next == level_reg[i])
                        lit_next[i] = 1'b0;
                    if (ramp_phase_next == '0)
                    begin
                        case (mode_reg[i])
                            lbp_pkg::MODE_UP:
                            begin
                                if (level_reg[i] >= pwm_levels_reg)
                                begin
                                    level_next[i] = pwm_levels_reg;
                                    mode_next[i]  = lbp_pkg::MODE_DOWN;
                                end
                                else
                                    level_next[i] = level_reg[i] + 1'b1;
                            end
                            lbp_pkg::MODE_DOWN:
                            begin
                                if (level_reg[i] == '0)
                                    mode_next[i] = lbp_pkg::MODE_IDLE;
                                else
                                    level_next[i] = level_reg[i] - 1'b1;
                            end
                            default:
                            begin
                                mode_next[i] = mode_reg[i];
                            end
                        endcase
                    end
                end
            end
            else if ({3'b000, led_index} == lbp_pkg::CMP_W'(i))
            begin
                case (action)
                    lbp_pkg::ACT_ON:
                    begin
                        mode_next[i] = lbp_pkg::MODE_IDLE;
                        lit_next[i]  = 1'b1;
                    end
                    lbp_pkg::ACT_OFF:
                    begin
                        mode_next[i] = lbp_pkg::MODE_IDLE;
                        lit_next[i]  = 1'b0;
                    end
                    lbp_pkg::ACT_FLASH:
                    begin
                        mode_next[i]  = lbp_pkg::MODE_UP;
                        level_next[i] = '0;
                    end
                    default:
                    begin
                        mode_next[i] = mode_reg[i];
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        index_flashing = 1'b0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if ({3'b000, led_index} == lbp_pkg::CMP_W'(i)
                && mode_next[i] != lbp_pkg::MODE_IDLE)
                index_flashing = 1'b1;
        end
    end

    // LEDs beyond the mask width run but are not reported
    for (genvar g = 0; g < MW; g++)
    begin : g_mask
        if (g < LED_COUNT)
        begin : g_led
            assign on_mask[g] = lit_next[g];
            assign fl_mask[g] = (mode_next[g] != lbp_pkg::MODE_IDLE);
        end
        else
        begin : g_none
            assign on_mask[g] = 1'b0;
            assign fl_mask[g] = 1'b0;
        end
    end

    assign out_data_next = {3'b000, index_flashing, fl_mask, on_mask};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_levels_reg    <= lbp_pkg::PWM_LEVELS_RST;
            ramp_interval_reg <= lbp_pkg::RAMP_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbp_pkg::CFG_PWM_LEVELS:    pwm_levels_reg    <= cfg_wdata;
                lbp_pkg::CFG_RAMP_INTERVAL: ramp_interval_reg <= cfg_wdata;
                default:                    pwm_levels_reg    <= pwm_levels_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_phase_reg  <= '0;
            ramp_phase_reg <= '0;
            lit_reg        <= '0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                mode_reg[i]  <= lbp_pkg::MODE_IDLE;
                level_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            pwm_phase_reg  <= pwm_phase_next;
            ramp_phase_reg <= ramp_phase_next;
            lit_reg        <= lit_next;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                mode_reg[i]  <= mode_next[i];
                level_reg[i] <= level_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

/* verif/led_breathing_pwm_bank_unit_tb.sv */
module led_breathing_pwm_bank_unit_tb;

    localparam int BANK_SIZE = 14;

    typedef struct packed {
        logic [lbp_pkg::MASK_W-1:0] lit_mask;
        logic [lbp_pkg::MASK_W-1:0] flash_mask;
        logic                       addr_flashing;
    } bank_view_t;

    typedef struct packed {
        lbp_pkg::action_t          act;
        logic [lbp_pkg::IDX_W-1:0] idx;
        logic                      typed;
        bank_view_t                view;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;

    // typed rows follow from reset values: pwm_levels 10, ramp_interval 20
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{lbp_pkg::ACT_TICK,  4'd0,  1'b1, '{14'h0000, 14'h0000, 1'b0}},
        '{lbp_pkg::ACT_ON,    4'd0,  1'b1, '{14'h0001, 14'h0000, 1'b0}},
        '{lbp_pkg::ACT_ON,    4'd13, 1'b1, '{14'h2001, 14'h0000, 1'b0}},
        '{lbp_pkg::ACT_OFF,   4'd15, 1'b1, '{14'h2001, 14'h0000, 1'b0}},
        '{lbp_pkg::ACT_ON,    4'd14, 1'b1, '{14'h2001, 14'h0000, 1'b0}},
        '{lbp_pkg::ACT_FLASH, 4'd13, 1'b1, '{14'h2001, 14'h2000, 1'b1}},
        '{lbp_pkg::ACT_FLASH, 4'd15, 1'b1, '{14'h2001, 14'h2000, 1'b0}},
        '{lbp_pkg::ACT_TICK,  4'd13, 1'b1, '{14'h0001, 14'h2000, 1'b1}},
        '{lbp_pkg::ACT_FLASH, 4'd0,  1'b1, '{14'h0001, 14'h2001, 1'b1}},
        '{lbp_pkg::ACT_OFF,   4'd0,  1'b1, '{14'h0000, 14'h2000, 1'b0}},
        '{lbp_pkg::ACT_FLASH, 4'd7,  1'b1, '{14'h0000, 14'h2080, 1'b1}},
        '{lbp_pkg::ACT_TICK,  4'd15, 1'b1, '{14'h0000, 14'h2080, 1'b0}},
        '{lbp_pkg::ACT_ON,    4'd13, 1'b1, '{14'h2000, 14'h0080, 1'b0}},
        '{lbp_pkg::ACT_TICK,  4'd7,  1'b0, '0},
        '{lbp_pkg::ACT_FLASH, 4'd10, 1'b0, '0},
        '{lbp_pkg::ACT_TICK,  4'd10, 1'b0, '0},
        '{lbp_pkg::ACT_OFF,   4'd7,  1'b1, '{14'h2000, 14'h0400, 1'b0}},
        '{lbp_pkg::ACT_TICK,  4'd0,  1'b0, '0},
        '{lbp_pkg::ACT_TICK,  4'd3,  1'b0, '0},
        '{lbp_pkg::ACT_FLASH, 4'd14, 1'b1, '{14'h2000, 14'h0400, 1'b0}},
        '{lbp_pkg::ACT_TICK,  4'd10, 1'b0, '0},
        '{lbp_pkg::ACT_ON,    4'd10, 1'b0, '0},
        '{lbp_pkg::ACT_TICK,  4'd12, 1'b0, '0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [lbp_pkg::LEVEL_W-1:0]    cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [lbp_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lbp_pkg::OUT_DATA_W-1:0] m_tdata;

    // predicted bank state
    logic [lbp_pkg::LEVEL_W-1:0] pwm_levels_m;
    logic [lbp_pkg::LEVEL_W-1:0] ramp_interval_m;
    logic [lbp_pkg::LEVEL_W-1:0] pwm_phase_m;
    logic [lbp_pkg::LEVEL_W-1:0] ramp_phase_m;
    lbp_pkg::mode_t              lamp_mode [BANK_SIZE];
    logic [lbp_pkg::LEVEL_W-1:0] lamp_level [BANK_SIZE];
    bit                          lamp_lit [BANK_SIZE];

    bank_view_t pending_views [$];
    int         mismatch_count = 0;
    int         results_seen = 0;
    int         burst_left = 0;
    bit         long_hold_done = 1'b0;

    led_breathing_pwm_bank_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    task automatic clear_bank();
        pwm_levels_m    = lbp_pkg::PWM_LEVELS_RST;
        ramp_interval_m = lbp_pkg::RAMP_INTERVAL_RST;
        pwm_phase_m     = '0;
        ramp_phase_m    = '0;
        for (int i = 0; i < BANK_SIZE; i++)
        begin
            lamp_mode[i]  = lbp_pkg::MODE_IDLE;
            lamp_level[i] = '0;
            lamp_lit[i]   = 1'b0;
        end
    endtask

    task automatic advance_bank(input lbp_pkg::action_t act,
                                input logic [lbp_pkg::IDX_W-1:0] idx,
                                output bank_view_t view);
        logic [lbp_pkg::LEVEL_W:0] next_pwm;
        logic [lbp_pkg::LEVEL_W:0] next_ramp;
        bit                        in_range;
        in_range = (idx < BANK_SIZE);
        if (act == lbp_pkg::ACT_TICK)
        begin
            next_pwm  = {1'b0, pwm_phase_m} + 1'b1;
            next_ramp = {1'b0, ramp_phase_m} + 1'b1;
            pwm_phase_m  = (next_pwm >= {1'b0, pwm_levels_m}) ?
                           '0 : next_pwm[lbp_pkg::LEVEL_W-1:0];
            ramp_phase_m = (next_ramp > {1'b0, ramp_interval_m}) ?
                           '0 : next_ramp[lbp_pkg::LEVEL_W-1:0];
            for (int i = 0; i < BANK_SIZE; i++)
            begin
                if (lamp_mode[i] != lbp_pkg::MODE_IDLE)
                begin
                    if (lamp_level[i] == 0)
                        lamp_lit[i] = 1'b0;
                    else if (lamp_level[i] == pwm_levels_m)
                        lamp_lit[i] = 1'b1;
                    else if (pwm_phase_m == 0)
                        lamp_lit[i] = 1'b1;
                    else if (pwm_phase_m == lamp_level[i])
                        lamp_lit[i] = 1'b0;
                    if (ramp_phase_m == 0)
                    begin
                        if (lamp_mode[i] == lbp_pkg::MODE_UP)
                        begin
                            if ({1'b0, lamp_level[i]} + 1'b1 > {1'b0, pwm_levels_m})
                            begin
                                lamp_level[i] = pwm_levels_m;
                                lamp_mode[i]  = lbp_pkg::MODE_DOWN;
                            end
                            else
                                lamp_level[i] = lamp_level[i] + 1'b1;
                        end
                        else if (lamp_level[i] == 0)
                            lamp_mode[i] = lbp_pkg::MODE_IDLE;
                        else
                            lamp_level[i] = lamp_level[i] - 1'b1;
                    end
                end
            end
        end
        else if (in_range)
        begin
            case (act)
                lbp_pkg::ACT_ON:
                begin
                    lamp_mode[idx] = lbp_pkg::MODE_IDLE;
                    lamp_lit[idx]  = 1'b1;
                end
                lbp_pkg::ACT_OFF:
                begin
                    lamp_mode[idx] = lbp_pkg::MODE_IDLE;
                    lamp_lit[idx]  = 1'b0;
                end
                default:
                begin
                    lamp_mode[idx]  = lbp_pkg::MODE_UP;
                    lamp_level[idx] = '0;
                end
            endcase
        end
        for (int i = 0; i < BANK_SIZE; i++)
        begin
            view.lit_mask[i]   = lamp_lit[i];
            view.flash_mask[i] = (lamp_mode[i] != lbp_pkg::MODE_IDLE);
        end
        view.addr_flashing = in_range ? (lamp_mode[idx] != lbp_pkg::MODE_IDLE) : 1'b0;
    endtask

    task automatic offer_item(input lbp_pkg::action_t act,
                              input logic [lbp_pkg::IDX_W-1:0] idx,
                              input logic typed, input bank_view_t typed_view);
        bank_view_t view;
        int         gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(lbp_pkg::IN_DATA_W-lbp_pkg::IDX_W){1'b0}}, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_bank(act, idx, view);
        pending_views.push_back(typed ? typed_view : view);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic random_item();
        int               pick;
        lbp_pkg::action_t act;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            act = lbp_pkg::ACT_TICK;
        else if (pick < 75)
            act = lbp_pkg::ACT_FLASH;
        else if (pick < 88)
            act = lbp_pkg::ACT_ON;
        else
            act = lbp_pkg::ACT_OFF;
        offer_item(act, lbp_pkg::IDX_W'($urandom_range(0, 15)), 1'b0, '0);
    endtask

    // registers are only touched once the bank has gone quiet
    task automatic program_bank(input logic [lbp_pkg::LEVEL_W-1:0] levels,
                                input logic [lbp_pkg::LEVEL_W-1:0] interval);
        s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lbp_pkg::CFG_PWM_LEVELS;
        cfg_wdata <= levels;
        @(posedge clk);
        cfg_index <= lbp_pkg::CFG_RAMP_INTERVAL;
        cfg_wdata <= interval;
        @(posedge clk);
        cfg_we <= 1'b0;
        pwm_levels_m    = levels;
        ramp_interval_m = interval;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [lbp_pkg::LEVEL_W-1:0] levels,
                             input logic [lbp_pkg::LEVEL_W-1:0] interval,
                             input int count);
        program_bank(levels, interval);
        repeat (count) random_item();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= lbp_pkg::CFG_PWM_LEVELS;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= lbp_pkg::ACT_TICK;
        clear_bank();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_item(DIRECTED[r].act, DIRECTED[r].idx, DIRECTED[r].typed, DIRECTED[r].view);

        repeat (180) random_item();
        run_phase(8'd1, 8'd0, 150);
        // fast ramp to high levels, then shrink the range under brightening LEDs
        run_phase(8'd200, 8'd0, 150);
        run_phase(8'd3, 8'd0, 120);
        run_phase(8'd0, 8'd2, 100);
        run_phase(8'd255, 8'd255, 100);
        repeat (3)
            run_phase(lbp_pkg::LEVEL_W'($urandom_range(1, 16)),
                      lbp_pkg::LEVEL_W'($urandom_range(0, 4)), 80);

        s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: spans of steady, patchy or sparse acceptance, plus one long hold-off
    initial
    begin
        int stall_mode;
        int span;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= 300)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            stall_mode = $urandom_range(0, 2);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        bank_view_t want;
        bank_view_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.lit_mask      = m_tdata[lbp_pkg::MASK_W-1:0];
            got.flash_mask    = m_tdata[2*lbp_pkg::MASK_W-1:lbp_pkg::MASK_W];
            got.addr_flashing = m_tdata[2*lbp_pkg::MASK_W];
            if (pending_views.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: item with nothing expected, got %h", $time, m_tdata);
            end
            else
            begin
                want = pending_views.pop_front();
                if (got.lit_mask !== want.lit_mask)
                begin
                    mismatch_count++;
                    $display("%0t: led_on_mask expected %h got %h",
                             $time, want.lit_mask, got.lit_mask);
                end
                if (got.flash_mask !== want.flash_mask)
                begin
                    mismatch_count++;
                    $display("%0t: flashing_mask expected %h got %h",
                             $time, want.flash_mask, got.flash_mask);
                end
                if (got.addr_flashing !== want.addr_flashing)
                begin
                    mismatch_count++;
                    $display("%0t: index_flashing expected %b got %b",
                             $time, want.addr_flashing, got.addr_flashing);
                end
            end
        end
    end

endmodule
